// ===== rtl/bsfp_pkg.sv =====
package bsfp_pkg;

	localparam int MODE_MAX    = 12;
	localparam int SPEED_MAX   = 5;
	localparam int LEVEL_COUNT = 4;
	localparam int STEP_WRAP   = 384;
	localparam int PIXELS      = 32;

	localparam int TIME_W   = 32;
	localparam int MODE_W   = 4;
	localparam int SPEED_W  = 3;
	localparam int LEVEL_W  = 2;
	localparam int ASTEP_W  = 9;
	localparam int FSTEP_W  = 6;
	localparam int BRIGHT_W = 8;
	localparam int HOLD_W   = 4;
	localparam int DELAY_W  = 4;

	// Number of modes that have an entry in the delay table.
	localparam int DELAY_ENTRIES = 13;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 4'd5;
	localparam logic [HOLD_W-1:0]  HOLD_THR_RESET = 4'd10;

	localparam logic [MODE_W-1:0]   MODE_LAST  = MODE_W'(MODE_MAX);
	localparam logic [SPEED_W-1:0]  SPEED_LAST = SPEED_W'(SPEED_MAX);
	localparam logic [LEVEL_W-1:0]  LEVEL_LAST = LEVEL_W'(LEVEL_COUNT - 1);
	localparam logic [ASTEP_W-1:0]  ASTEP_LAST = ASTEP_W'(STEP_WRAP);
	localparam logic [FSTEP_W-1:0]  FSTEP_LAST = FSTEP_W'(PIXELS);
	localparam logic [BRIGHT_W-1:0] BRIGHT_STEP = BRIGHT_W'(255 / LEVEL_COUNT);
	localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 8'd255;

	typedef struct packed {
		logic              armed;
		logic [HOLD_W-1:0] count;
		logic              fire;
	} qual_t;

	// One hold qualifier update for one tick.
	function automatic qual_t qualify(input logic armed, input logic [HOLD_W-1:0] count,
	                                  input logic pin, input logic [HOLD_W-1:0] thr);
		logic [HOLD_W:0] nxt;
		qual_t           q;
		nxt     = {1'b0, count} + {{HOLD_W{1'b0}}, 1'b1};
		q.armed = armed;
		q.count = count;
		q.fire  = 1'b0;
		if (armed) begin
			if (!pin) begin
				q.armed = 1'b0;
				q.count = '0;
			end else if (nxt > {1'b0, thr}) begin
				q.armed = 1'b0;
				q.count = '0;
				q.fire  = 1'b1;
			end else begin
				q.count = nxt[HOLD_W-1:0];
			end
		end
		return q;
	endfunction

	function automatic logic [DELAY_W-1:0] delay_of_mode(input logic [MODE_W-1:0] mode);
		logic [DELAY_W-1:0] d;
		unique case (mode)
			4'd0:    d = 4'd1;
			4'd1:    d = 4'd1;
			4'd2:    d = 4'd10;
			4'd7:    d = 4'd8;
			4'd10:   d = 4'd3;
			4'd12:   d = 4'd10;
			default: d = 4'd5;
		endcase
		return d;
	endfunction

	function automatic logic [BRIGHT_W-1:0] brightness_of(input logic [LEVEL_W-1:0] lvl);
		logic [LEVEL_W:0]    rem;
		logic [BRIGHT_W+LEVEL_W:0] prod;
		rem  = (LEVEL_W+1)'(LEVEL_COUNT) - {1'b0, lvl};
		prod = {{(LEVEL_W+1){1'b0}}, BRIGHT_STEP} * {{BRIGHT_W{1'b0}}, rem};
		if (lvl == '0) begin
			return BRIGHT_FULL;
		end
		return prod[BRIGHT_W-1:0];
	endfunction

endpackage

// ===== rtl/bsfp_if.sv =====
interface bsfp_tick_if;
	logic                          valid;
	logic                          ready;
	logic                          mode_press;
	logic                          speed_press;
	logic                          level_press;
	logic                          mode_pin;
	logic                          speed_pin;
	logic                          level_pin;
	logic [bsfp_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, mode_press, speed_press, level_press,
	                mode_pin, speed_pin, level_pin, now_ms, input ready);
	modport sink (input valid, mode_press, speed_press, level_press,
	              mode_pin, speed_pin, level_pin, now_ms, output ready);
endinterface

interface bsfp_frame_if;
	logic                          valid;
	logic                          ready;
	logic                          draw_frame;
	logic [bsfp_pkg::MODE_W-1:0]   frame_mode;
	logic [bsfp_pkg::ASTEP_W-1:0]  anim_step_out;
	logic [bsfp_pkg::FSTEP_W-1:0]  frame_step_out;
	logic [bsfp_pkg::SPEED_W-1:0]  speed_out;
	logic [bsfp_pkg::LEVEL_W-1:0]  level_out;
	logic [bsfp_pkg::BRIGHT_W-1:0] strip_brightness;
	logic                          brightness_update;

	modport source (output valid, draw_frame, frame_mode, anim_step_out, frame_step_out,
	                speed_out, level_out, strip_brightness, brightness_update, input ready);
	modport sink (input valid, draw_frame, frame_mode, anim_step_out, frame_step_out,
	              speed_out, level_out, strip_brightness, brightness_update, output ready);
endinterface

// ===== rtl/button_setting_frame_pacer.sv =====
// Channel   Direction  Word
// tick      in         press events and pin levels of three buttons, millisecond time
// frame     out        frame grant, mode, steps, speed, level, strip brightness
// APB       in/out     register 0: hold threshold (4 bits)
//
// A word is captured in an input register and its result is then registered into the
// output register; one word is taken every cycle while the output is consumed. The
// settings and step counters update in the same cycle as the output register. A
// stalled output stops the input register and then tick.ready.
// Reset clears all settings, qualifiers and counters; the hold threshold returns to 10.
module button_setting_frame_pacer (
	input  logic               clk,
	input  logic               arst_n,
	bsfp_tick_if.sink          tick,
	bsfp_frame_if.source       frame,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic ADDR_HOLD_THR = 1'b0;

	// Configuration
	logic [bsfp_pkg::HOLD_W-1:0] hold_thr_q;

	// Input register
	logic                          valid_s1;
	logic                          mode_press_s1, speed_press_s1, level_press_s1;
	logic                          mode_pin_s1, speed_pin_s1, level_pin_s1;
	logic [bsfp_pkg::TIME_W-1:0]   now_s1;

	// Block state
	logic                          mode_armed_q, speed_armed_q, level_armed_q;
	logic [bsfp_pkg::HOLD_W-1:0]   mode_cnt_q, speed_cnt_q, level_cnt_q;
	logic [bsfp_pkg::MODE_W-1:0]   mode_q;
	logic [bsfp_pkg::SPEED_W-1:0]  speed_q;
	logic [bsfp_pkg::LEVEL_W-1:0]  level_q;
	logic                          force_q;
	logic [bsfp_pkg::DELAY_W-1:0]  delay_q;
	logic [bsfp_pkg::TIME_W-1:0]   last_ms_q;
	logic [bsfp_pkg::ASTEP_W-1:0]  astep_q;
	logic [bsfp_pkg::FSTEP_W-1:0]  fstep_q;

	// Output register
	logic                          out_valid_q;
	logic                          draw_q, bupd_q;
	logic [bsfp_pkg::MODE_W-1:0]   mode_out_q;
	logic [bsfp_pkg::ASTEP_W-1:0]  astep_out_q;
	logic [bsfp_pkg::FSTEP_W-1:0]  fstep_out_q;
	logic [bsfp_pkg::SPEED_W-1:0]  speed_out_q;
	logic [bsfp_pkg::LEVEL_W-1:0]  level_out_q;
	logic [bsfp_pkg::BRIGHT_W-1:0] bright_q;

	// Combinational next values
	logic                          adv;
	bsfp_pkg::qual_t               lvl_qual, spd_qual, mod_qual;
	logic [bsfp_pkg::LEVEL_W-1:0]  level_d;
	logic [bsfp_pkg::SPEED_W-1:0]  speed_d;
	logic [bsfp_pkg::MODE_W-1:0]   mode_d;
	logic                          force_mid;
	logic [bsfp_pkg::ASTEP_W-1:0]  astep_mid;
	logic [bsfp_pkg::FSTEP_W-1:0]  fstep_mid;
	logic [bsfp_pkg::TIME_W-1:0]   elapsed;
	logic [bsfp_pkg::DELAY_W+bsfp_pkg::SPEED_W-1:0] need;
	logic                          draw_d;

	assign adv        = valid_s1 && (!out_valid_q || frame.ready);
	assign tick.ready = !valid_s1 || adv;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_HOLD_THR) ? {{(32-bsfp_pkg::HOLD_W){1'b0}}, hold_thr_q}
	                                            : 32'd0;

	always_comb begin
		lvl_qual = bsfp_pkg::qualify(level_armed_q | level_press_s1, level_cnt_q,
		                             level_pin_s1, hold_thr_q);
		spd_qual = bsfp_pkg::qualify(speed_armed_q | speed_press_s1, speed_cnt_q,
		                             speed_pin_s1, hold_thr_q);
		mod_qual = bsfp_pkg::qualify(mode_armed_q | mode_press_s1, mode_cnt_q,
		                             mode_pin_s1, hold_thr_q);

		level_d   = level_q;
		force_mid = force_q;
		if (lvl_qual.fire) begin
			level_d = (level_q == bsfp_pkg::LEVEL_LAST) ? '0 : level_q + 1'b1;
			// Wrapping back to full brightness while paused shows one frame.
			if (level_q == bsfp_pkg::LEVEL_LAST && speed_q == bsfp_pkg::SPEED_LAST) begin
				force_mid = 1'b1;
			end
		end

		speed_d = speed_q;
		if (spd_qual.fire) begin
			speed_d = (speed_q == bsfp_pkg::SPEED_LAST) ? '0 : speed_q + 1'b1;
		end

		mode_d    = mode_q;
		astep_mid = astep_q;
		fstep_mid = fstep_q;
		if (mod_qual.fire) begin
			mode_d    = (mode_q == bsfp_pkg::MODE_LAST) ? '0 : mode_q + 1'b1;
			astep_mid = '0;
			fstep_mid = '0;
			if (speed_d == bsfp_pkg::SPEED_LAST) begin
				force_mid = 1'b1;
			end
		end

		elapsed = now_s1 - last_ms_q;
		need    = {{bsfp_pkg::SPEED_W{1'b0}}, delay_q} * {{bsfp_pkg::DELAY_W{1'b0}}, speed_d};
		draw_d  = (elapsed >= bsfp_pkg::TIME_W'(need)) &&
		          !(speed_d == bsfp_pkg::SPEED_LAST && !force_mid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_thr_q <= bsfp_pkg::HOLD_THR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_HOLD_THR) begin
			hold_thr_q <= pwdata[bsfp_pkg::HOLD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			mode_press_s1  <= tick.mode_press;
			speed_press_s1 <= tick.speed_press;
			level_press_s1 <= tick.level_press;
			mode_pin_s1    <= tick.mode_pin;
			speed_pin_s1   <= tick.speed_pin;
			level_pin_s1   <= tick.level_pin;
			now_s1         <= tick.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_armed_q  <= 1'b0;
			speed_armed_q <= 1'b0;
			level_armed_q <= 1'b0;
			mode_cnt_q    <= '0;
			speed_cnt_q   <= '0;
			level_cnt_q   <= '0;
			mode_q        <= '0;
			speed_q       <= '0;
			level_q       <= '0;
			force_q       <= 1'b0;
			delay_q       <= bsfp_pkg::DELAY_RESET;
			last_ms_q     <= '0;
			astep_q       <= '0;
			fstep_q       <= '0;
		end else if (adv) begin
			mode_armed_q  <= mod_qual.armed;
			speed_armed_q <= spd_qual.armed;
			level_armed_q <= lvl_qual.armed;
			mode_cnt_q    <= mod_qual.count;
			speed_cnt_q   <= spd_qual.count;
			level_cnt_q   <= lvl_qual.count;
			mode_q        <= mode_d;
			speed_q       <= speed_d;
			level_q       <= level_d;
			if (draw_d) begin
				force_q   <= 1'b0;
				last_ms_q <= now_s1;
				if (32'(mode_d) < 32'(bsfp_pkg::DELAY_ENTRIES)) begin
					delay_q <= bsfp_pkg::delay_of_mode(mode_d);
				end
				astep_q <= (astep_mid == bsfp_pkg::ASTEP_LAST) ? '0 : astep_mid + 1'b1;
				fstep_q <= (fstep_mid == bsfp_pkg::FSTEP_LAST) ? '0 : fstep_mid + 1'b1;
			end else begin
				force_q <= force_mid;
				astep_q <= astep_mid;
				fstep_q <= fstep_mid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			draw_q      <= draw_d;
			mode_out_q  <= mode_d;
			astep_out_q <= astep_mid;
			fstep_out_q <= fstep_mid;
			speed_out_q <= speed_d;
			level_out_q <= level_d;
			bright_q    <= bsfp_pkg::brightness_of(level_d);
			bupd_q      <= lvl_qual.fire;
		end
	end

	assign frame.valid             = out_valid_q;
	assign frame.draw_frame        = draw_q;
	assign frame.frame_mode        = mode_out_q;
	assign frame.anim_step_out     = astep_out_q;
	assign frame.frame_step_out    = fstep_out_q;
	assign frame.speed_out         = speed_out_q;
	assign frame.level_out         = level_out_q;
	assign frame.strip_brightness  = bright_q;
	assign frame.brightness_update = bupd_q;

`ifndef SYNTHESIS
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		speed_q <= bsfp_pkg::SPEED_LAST)
		else $error("speed setting out of range");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= bsfp_pkg::MODE_LAST)
		else $error("mode setting out of range");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(level_armed_q || level_cnt_q == '0) && (speed_armed_q || speed_cnt_q == '0) &&
		(mode_armed_q || mode_cnt_q == '0))
		else $error("hold count kept by a disarmed qualifier");

	a_frame_time: assert property (@(posedge clk) disable iff (!arst_n)
		adv && draw_d |=> last_ms_q == $past(now_s1) && !force_q)
		else $error("granted frame did not record its time");

	a_bupd_level: assert property (@(posedge clk) disable iff (!arst_n)
		adv && lvl_qual.fire |=> level_q != $past(level_q))
		else $error("brightness update without a level change");
`endif

endmodule
